FILE: design/nonce_anti_replay_window_check_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nonce anti-replay window check
// Clocked assertion wrappers; defining ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef NONCE_ANTI_REPLAY_WINDOW_CHECK_ASSERT_SVH
`define NONCE_ANTI_REPLAY_WINDOW_CHECK_ASSERT_SVH

`ifndef ASSERT_OFF

`define NARWC_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define NARWC_ASSERT(label, prop, msg) \
   `NARWC_ASSERT_CLK(label, clock, reset, prop, msg)

`else

`define NARWC_ASSERT_CLK(label, clk, rst, prop, msg)

`define NARWC_ASSERT(label, prop, msg)

`endif

`endif

FILE: design/narwc_pkg.sv
// ----------------------------------------------------------------------------
// narwc_pkg
// Beat types and status codes of the nonce anti-replay window check.
// ----------------------------------------------------------------------------
package narwc_pkg;

   localparam int DIR_POS = 31;   // direction bit of the nonce word
   localparam int ID_W    = 31;   // sender id bits below it

   typedef enum logic [3:0] {
      ST_NEW_AGENT  = 4'd0,
      ST_NEWER_BOOT = 4'd1,
      ST_NEW_HIGH   = 4'd2,
      ST_IN_WINDOW  = 4'd3,
      ST_WRONG_DIR  = 4'd4,
      ST_STALE_BOOT = 4'd5,
      ST_TOO_OLD    = 4'd6,
      ST_REPLAY     = 4'd7,
      ST_ID_RANGE   = 4'd8
   } status_type;

   typedef struct packed {
      logic [31:0] dir_agent_word;
      logic [31:0] boot_id;
      logic [31:0] msg_counter;
      logic        expect_master;
   } req_type;

   typedef struct packed {
      logic       accepted;
      status_type status;
   } rsp_type;

endpackage

FILE: design/nonce_anti_replay_window_check.sv
// ----------------------------------------------------------------------------
// nonce_anti_replay_window_check
// Per-sender anti-replay check of received nonces against a sliding window.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_stall/req_data carry one nonce per beat together with the
//   expected direction. rsp_valid/rsp_stall/rsp_data return one verdict per
//   nonce: an accepted flag and a status code.
//   Per-sender state (valid mark, last boot id, highest counter, seen-window)
//   sits in one single-port-write table memory of AGENTS entries.
//   Each nonce goes through the table read at the accepting edge, the S_EVAL
//   state to evaluate, and the S_WRITE state to write back and load the
//   result register. No new nonce is taken until the read-modify-write of
//   the table entry for the last one is done.
//   After reset a clearing pass writes every table entry invalid, one entry
//   a cycle; req_stall is high during it.
//   A new nonce is taken while an earlier verdict still waits in the rsp
//   register. When rsp_stall holds that register, the write-back waits
//   until the register frees up, and req_stall stays high meanwhile.
// ----------------------------------------------------------------------------
`include "nonce_anti_replay_window_check_assert.svh"

module nonce_anti_replay_window_check
   import narwc_pkg::*;
#(
   parameter int WINDOW_BITS = 256,
   parameter int AGENTS      = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW      = $clog2(AGENTS);
   localparam int WB      = $clog2(WINDOW_BITS);
   localparam int ENTRY_W = 1 + 32 + 32 + WINDOW_BITS;

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_EVAL  = 5'b00100,
      S_WRITE = 5'b01000,
      S_SPARE = 5'b10000
   } state_type;

   typedef enum logic [1:0] {
      K_NONE  = 2'd0,
      K_FRESH = 2'd1,
      K_SHIFT = 2'd2,
      K_SET   = 2'd3
   } kind_type;

   state_type               state_ff, state_in;
   logic [AW-1:0]           clr_ff, clr_in;
   req_type                 item_ff;
   logic [ENTRY_W-1:0]      entry_mem [AGENTS];
   logic [ENTRY_W-1:0]      rd_ff;
   kind_type                kind_ff, kind_in;
   status_type              st_ff, st_in;
   logic [WB-1:0]           amt_ff, amt_in;
   logic                    big_ff, big_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff;

   logic                    req_accept;
   logic                    req_in_range;
   logic [AW-1:0]           req_idx;
   logic                    item_in_range;
   logic                    item_dir_bad;
   logic [AW-1:0]           item_idx;
   logic                    rd_valid;
   logic [31:0]             rd_boot;
   logic [31:0]             rd_high;
   logic [WINDOW_BITS-1:0]  rd_win;
   logic [31:0]             diff_up;
   logic [31:0]             diff_dn;
   logic                    rsp_free;
   logic                    finish;
   logic                    mem_we;
   logic [AW-1:0]           mem_wa;
   logic [ENTRY_W-1:0]      mem_wd;
   logic [31:0]             new_boot;
   logic [31:0]             new_high;
   logic [WINDOW_BITS-1:0]  new_win;

   assign req_stall    = (state_ff != S_IDLE);
   assign req_accept   = req_valid && !req_stall;
   assign req_in_range = {1'b0, req_data.dir_agent_word[ID_W-1:0]} < 32'(AGENTS);
   assign req_idx      = req_data.dir_agent_word[AW-1:0];

   assign item_dir_bad  = item_ff.dir_agent_word[DIR_POS] != item_ff.expect_master;
   assign item_in_range = {1'b0, item_ff.dir_agent_word[ID_W-1:0]} < 32'(AGENTS);
   assign item_idx      = item_ff.dir_agent_word[AW-1:0];

   assign rd_valid = rd_ff[ENTRY_W-1];
   assign rd_boot  = rd_ff[ENTRY_W-2 -: 32];
   assign rd_high  = rd_ff[WINDOW_BITS +: 32];
   assign rd_win   = rd_ff[WINDOW_BITS-1:0];

   assign diff_up = item_ff.msg_counter - rd_high;
   assign diff_dn = rd_high - item_ff.msg_counter;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign finish   = (state_ff == S_WRITE) && rsp_free;

   // verdict
   always_comb begin
      st_in  = ST_WRONG_DIR;
      kind_in = K_NONE;
      amt_in = diff_up[WB-1:0];
      big_in = diff_up >= 32'(WINDOW_BITS);
      if (item_dir_bad) begin
         st_in = ST_WRONG_DIR;
      end else if (!item_in_range) begin
         st_in = ST_ID_RANGE;
      end else if (!rd_valid) begin
         st_in   = ST_NEW_AGENT;
         kind_in = K_FRESH;
      end else if (item_ff.boot_id > rd_boot) begin
         st_in   = ST_NEWER_BOOT;
         kind_in = K_FRESH;
      end else if (item_ff.boot_id < rd_boot) begin
         st_in = ST_STALE_BOOT;
      end else if (item_ff.msg_counter > rd_high) begin
         st_in   = ST_NEW_HIGH;
         kind_in = K_SHIFT;
      end else if (diff_dn >= 32'(WINDOW_BITS)) begin
         st_in = ST_TOO_OLD;
      end else if (rd_win[diff_dn[WB-1:0]]) begin
         st_in = ST_REPLAY;
      end else begin
         st_in   = ST_IN_WINDOW;
         kind_in = K_SET;
         amt_in  = diff_dn[WB-1:0];
      end
   end

   // write-back data
   always_comb begin
      new_boot = rd_boot;
      new_high = item_ff.msg_counter;
      new_win  = WINDOW_BITS'(1);
      case (kind_ff)
         K_FRESH: begin
            new_boot = item_ff.boot_id;
         end
         K_SHIFT: begin
            new_win = (big_ff ? '0 : (rd_win << amt_ff)) | WINDOW_BITS'(1);
         end
         K_SET: begin
            new_high = rd_high;
            new_win  = rd_win | (WINDOW_BITS'(1) << amt_ff);
         end
         default: begin
            new_win = rd_win;
         end
      endcase
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = item_idx;
      mem_wd = {1'b1, new_boot, new_high, new_win};
      if (state_ff == S_CLEAR) begin
         mem_we = 1'b1;
         mem_wa = clr_ff;
         mem_wd = '0;
      end else if (finish && kind_ff != K_NONE) begin
         mem_we = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(AGENTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = S_WRITE;
         end
         S_WRITE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_data;
      end
      if (state_ff == S_EVAL) begin
         kind_ff <= kind_in;
         st_ff   <= st_in;
         amt_ff  <= amt_in;
         big_ff  <= big_in;
      end
      if (finish) begin
         rsp_ff.accepted <= (st_ff == ST_NEW_AGENT) || (st_ff == ST_NEWER_BOOT)
                         || (st_ff == ST_NEW_HIGH) || (st_ff == ST_IN_WINDOW);
         rsp_ff.status   <= st_ff;
      end
   end

   // table memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_wa] <= mem_wd;
      end
      if (req_accept && req_in_range) begin
         rd_ff <= entry_mem[req_idx];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `NARWC_ASSERT(a_rsp_from_write, $rose(rsp_valid_ff) |-> $past(state_ff == S_WRITE), "rsp without write-back")
   `NARWC_ASSERT(a_eval_after_idle, (state_ff == S_EVAL) |-> $past(state_ff == S_IDLE), "eval without a read")
   `NARWC_ASSERT(a_flag_matches, rsp_valid_ff |-> (rsp_ff.accepted == (rsp_ff.status <= ST_IN_WINDOW)), "accepted flag disagrees with status")
   `NARWC_ASSERT(a_write_on_accept, (mem_we && state_ff == S_WRITE) |-> (st_ff <= ST_IN_WINDOW), "table written for rejected nonce")

endmodule
